// ===== hw/rtl/psaf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psaf_pkg
// Shared sizes, codes and types of the pixel store with get, put and fill.
// ----------------------------------------------------------------------------
package psaf_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;

    // Widths of the effective image size (it can hold the maximum itself)
    localparam int COLS_W = $clog2(MAX_COLUMNS + 1);
    localparam int ROWS_W = $clog2(MAX_ROWS + 1);
    // Widths of a coordinate inside the image
    localparam int XW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int YW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    localparam int PIX_DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW        = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
    localparam int PIX_W     = 32;

    // Configuration port
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd2;

    localparam logic [1:0] FMT_RGBA32 = 2'd3;
    localparam logic [1:0] FMT_RESET  = 2'd2;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    localparam logic [1:0] OP_GET  = 2'd0;
    localparam logic [1:0] OP_PUT  = 2'd1;
    localparam logic [1:0] OP_FILL = 2'd2;

    typedef enum logic [1:0] {
        K_NOP  = 2'd0,
        K_GET  = 2'd1,
        K_PUT  = 2'd2,
        K_FILL = 2'd3
    } cmd_kind_t;

    // Effective configuration, sizes already saturated to the maxima
    typedef struct packed {
        logic [1:0]        format;
        logic [COLS_W-1:0] cols;
        logic [ROWS_W-1:0] rows;
    } cfg_t;

    // Classified command from the front to the back
    typedef struct packed {
        cmd_kind_t         kind;
        logic              in_range;
        logic [AW-1:0]     addr;
        logic [PIX_W-1:0]  word;
        logic [COLS_W-1:0] fill_w;
        logic [ROWS_W-1:0] fill_h;
    } cmd_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       in_range;
    } res_t;

endpackage

// ===== hw/rtl/psaf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psaf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module psaf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/psaf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psaf_front
// Accepts items, checks bounds, clips fills, forms the pixel word and the
// address, and holds the classified commands in a two-entry queue.
// ----------------------------------------------------------------------------
module psaf_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  psaf_pkg::cfg_t       cfg,
    input  logic                 hold,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           operation,
    input  logic signed [15:0]   x_pos,
    input  logic signed [15:0]   y_pos,
    input  logic [15:0]          fill_width,
    input  logic [15:0]          fill_height,
    input  logic [7:0]           red_in,
    input  logic [7:0]           green_in,
    input  logic [7:0]           blue_in,
    input  logic [7:0]           alpha_in,
    output logic                 cmd_valid,
    output psaf_pkg::cmd_t       cmd,
    input  logic                 cmd_pop
);

    import psaf_pkg::*;

    localparam int PW = YW + COLS_W;

    logic [15:0]       x_u;
    logic [15:0]       y_u;
    logic              hit;
    logic [PW-1:0]     prod;
    logic [COLS_W-1:0] rem_w;
    logic [ROWS_W-1:0] rem_h;
    logic [COLS_W-1:0] clip_w;
    logic [ROWS_W-1:0] clip_h;
    logic [7:0]        alpha_w;
    cmd_t              new_cmd;
    logic              accept;

    cmd_t        q_mem_reg [2];
    logic        q_head_reg;
    logic        q_tail_reg;
    logic [1:0]  q_count_reg;
    logic [1:0]  q_count_next;

    assign x_u = x_pos;
    assign y_u = y_pos;

    // Negative coordinates have bit 15 set and so fail the compares too
    assign hit = (x_u < 16'(cfg.cols)) && (y_u < 16'(cfg.rows));

    assign prod  = PW'(y_u[YW-1:0]) * PW'(cfg.cols);
    assign rem_w = cfg.cols - COLS_W'(x_u[XW-1:0]);
    assign rem_h = cfg.rows - ROWS_W'(y_u[YW-1:0]);
    assign clip_w = (fill_width < 16'(rem_w)) ? COLS_W'(fill_width) : rem_w;
    assign clip_h = (fill_height < 16'(rem_h)) ? ROWS_W'(fill_height) : rem_h;
    assign alpha_w = (cfg.format == FMT_RGBA32) ? alpha_in : ALPHA_OPAQUE;

    always_comb
    begin
        new_cmd.in_range = hit;
        new_cmd.addr     = AW'(prod) + AW'(x_u[XW-1:0]);
        new_cmd.word     = {alpha_w, red_in, green_in, blue_in};
        new_cmd.fill_w   = clip_w;
        new_cmd.fill_h   = clip_h;
        new_cmd.kind     = K_NOP;
        case (operation)
            OP_GET:  new_cmd.kind = hit ? K_GET : K_NOP;
            OP_PUT:  new_cmd.kind = hit ? K_PUT : K_NOP;
            OP_FILL:
            begin
                if (hit && (clip_w != '0) && (clip_h != '0))
                begin
                    new_cmd.kind = K_FILL;
                end
            end
            default:
            begin
                new_cmd.kind     = K_NOP;
                new_cmd.in_range = 1'b0;
            end
        endcase
    end

    assign full   = (q_count_reg == 2'd2) || hold;
    assign accept = push && !full;

    assign cmd_valid = (q_count_reg != 2'd0);
    assign cmd       = q_mem_reg[q_head_reg];

    always_comb
    begin
        q_count_next = q_count_reg;
        if (accept && !cmd_pop)
        begin
            q_count_next = q_count_reg + 2'd1;
        end
        else if (!accept && cmd_pop)
        begin
            q_count_next = q_count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_head_reg  <= 1'b0;
            q_tail_reg  <= 1'b0;
            q_count_reg <= 2'd0;
        end
        else
        begin
            q_count_reg <= q_count_next;
            if (accept)
            begin
                q_tail_reg <= ~q_tail_reg;
            end
            if (cmd_pop)
            begin
                q_head_reg <= ~q_head_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_mem_reg[q_tail_reg] <= new_cmd;
        end
    end

endmodule

// ===== hw/rtl/psaf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psaf_back
// Carries out commands on the pixel memory, runs the clearing pass and the
// fill sweep, and queues the results.
// ----------------------------------------------------------------------------
module psaf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  psaf_pkg::cfg_t cfg,
    input  logic           clear_req,
    output logic           clearing,
    input  logic           cmd_valid,
    input  psaf_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           empty,
    input  logic           pop,
    output psaf_pkg::res_t result
);

    import psaf_pkg::*;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_RUN   = 3'b010,
        ST_FILL  = 3'b100
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [AW-1:0]     clr_addr_reg;
    logic [AW-1:0]     addr_reg;
    logic [AW-1:0]     row_addr_reg;
    logic [COLS_W-1:0] col_left_reg;
    logic [ROWS_W-1:0] row_left_reg;
    logic [COLS_W-1:0] fill_w_reg;
    logic [PIX_W-1:0]  fill_word_reg;
    logic              res_valid_reg;
    logic              res_get_reg;
    logic              res_in_range_reg;

    res_t              oq_mem_reg [OQ_DEPTH];
    logic [OQ_AW-1:0]  oq_head_reg;
    logic [OQ_AW-1:0]  oq_tail_reg;
    logic [OQ_CW-1:0]  oq_count_reg;

    logic              issue;
    logic              oq_pop;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [PIX_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [PIX_W-1:0]  ram_rdata;
    res_t              res_word;
    logic [AW-1:0]     next_row_addr;

    assign clearing = (state_reg == ST_CLEAR);

    // Room is reserved for the result still in the read stage
    assign issue = (state_reg == ST_RUN) && cmd_valid &&
                   ((oq_count_reg + OQ_CW'(res_valid_reg)) < OQ_CW'(OQ_DEPTH));
    assign cmd_pop = issue;

    assign next_row_addr = row_addr_reg + AW'(cfg.cols);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cmd.addr;
        ram_wdata = cmd.word;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = fill_word_reg;
            end
            ST_RUN:
            begin
                ram_we = issue && (cmd.kind == K_PUT);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign ram_re = issue && (cmd.kind == K_GET);

    psaf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (PIX_DEPTH)
    ) u_pixel_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cmd.addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == AW'(PIX_DEPTH - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (issue && (cmd.kind == K_FILL))
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if ((col_left_reg == COLS_W'(1)) && (row_left_reg == ROWS_W'(1)))
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        if (clear_req)
        begin
            state_next = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= issue;
            if (clear_req)
            begin
                clr_addr_reg <= '0;
            end
            else if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            res_get_reg      <= (cmd.kind == K_GET);
            res_in_range_reg <= cmd.in_range;
            addr_reg         <= cmd.addr;
            row_addr_reg     <= cmd.addr;
            col_left_reg     <= cmd.fill_w;
            row_left_reg     <= cmd.fill_h;
            fill_w_reg       <= cmd.fill_w;
            fill_word_reg    <= cmd.word;
        end
        else if (state_reg == ST_FILL)
        begin
            if (col_left_reg == COLS_W'(1))
            begin
                col_left_reg <= fill_w_reg;
                row_left_reg <= row_left_reg - ROWS_W'(1);
                addr_reg     <= next_row_addr;
                row_addr_reg <= next_row_addr;
            end
            else
            begin
                col_left_reg <= col_left_reg - COLS_W'(1);
                addr_reg     <= addr_reg + AW'(1);
            end
        end
    end

    // Result of the command issued in the cycle before, read data now valid
    always_comb
    begin
        res_word = '0;
        res_word.in_range = res_in_range_reg;
        if (res_get_reg)
        begin
            res_word.red   = ram_rdata[23:16];
            res_word.green = ram_rdata[15:8];
            res_word.blue  = ram_rdata[7:0];
            res_word.alpha = (cfg.format == FMT_RGBA32) ? ram_rdata[31:24]
                                                        : ALPHA_OPAQUE;
        end
    end

    assign empty  = (oq_count_reg == '0);
    assign oq_pop = pop && !empty;
    assign result = oq_mem_reg[oq_head_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_head_reg  <= '0;
            oq_tail_reg  <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            if (res_valid_reg)
            begin
                oq_tail_reg <= oq_tail_reg + OQ_AW'(1);
            end
            if (oq_pop)
            begin
                oq_head_reg <= oq_head_reg + OQ_AW'(1);
            end
            oq_count_reg <= oq_count_reg + OQ_CW'(res_valid_reg) - OQ_CW'(oq_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid_reg)
        begin
            oq_mem_reg[oq_tail_reg] <= res_word;
        end
    end

endmodule

// ===== hw/rtl/pixel_store_access_fill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_store_access_fill
// Pixel store with per-pixel get and put and a clipped rectangle fill.
// ----------------------------------------------------------------------------
// An accepted item is queued as a command, issued to the memory, registered
// with any read data and written to the result queue, whose head the output
// ports show. Gets, puts, misses and empty fills issue back to back while
// the result queue has room; a fill holds the memory write port after issue
// until the last pixel of its clipped rectangle is written.
// Reset: control state clears at once, then a clearing pass writes zero to
// all 4096 pixel words, one a cycle; full stays high meanwhile. Each write
// to a known configuration register starts the same pass.
// ----------------------------------------------------------------------------
module pixel_store_access_fill (
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration
    input  logic                           cfg_we,
    input  logic [psaf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [psaf_pkg::CFG_W-1:0]     cfg_data,
    // Items in
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     operation,
    input  logic signed [15:0]             x_pos,
    input  logic signed [15:0]             y_pos,
    input  logic [15:0]                    fill_width,
    input  logic [15:0]                    fill_height,
    input  logic [7:0]                     red_in,
    input  logic [7:0]                     green_in,
    input  logic [7:0]                     blue_in,
    input  logic [7:0]                     alpha_in,
    // Results out
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     red_out,
    output logic [7:0]                     green_out,
    output logic [7:0]                     blue_out,
    output logic [7:0]                     alpha_out,
    output logic                           in_range
);

    import psaf_pkg::*;

    logic [1:0]       format_reg;
    logic [CFG_W-1:0] columns_reg;
    logic [CFG_W-1:0] rows_reg;
    logic             clear_req;
    cfg_t             cfg;
    logic             clearing;
    logic             cmd_valid;
    cmd_t             cmd;
    logic             cmd_pop;
    res_t             result;

    // Only the three listed registers exist; a write to any other index is
    // dropped and does not clear the store.
    assign clear_req = cfg_we && ((cfg_index == CFG_FORMAT) ||
                                  (cfg_index == CFG_COLUMNS) ||
                                  (cfg_index == CFG_ROWS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg  <= FMT_RESET;
            columns_reg <= '0;
            rows_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FORMAT:  format_reg  <= cfg_data[1:0];
                CFG_COLUMNS: columns_reg <= cfg_data;
                CFG_ROWS:    rows_reg    <= cfg_data;
                default:     format_reg  <= format_reg;
            endcase
        end
    end

    // Sizes above the store's limits saturate to the limits for addressing
    // and for the bounds checks. A zero size leaves every access a miss.
    always_comb
    begin
        cfg.format = format_reg;
        cfg.cols   = (32'(columns_reg) > 32'(MAX_COLUMNS)) ? COLS_W'(MAX_COLUMNS)
                                                           : COLS_W'(columns_reg);
        cfg.rows   = (32'(rows_reg) > 32'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS)
                                                     : ROWS_W'(rows_reg);
    end

    // The front classifies each item as it arrives and queues a command;
    // it is held off while the back is clearing the memory.
    psaf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .hold        (clearing),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .fill_width  (fill_width),
        .fill_height (fill_height),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .alpha_in    (alpha_in),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    // The back owns the pixel memory. When not clearing, it issues one command
    // a cycle while the result queue has room, and stays on a fill until its
    // last pixel is written. The result of a fill is queued when the fill
    // starts, so results keep item order while later gets still see the fill.
    psaf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .clear_req (clear_req),
        .clearing  (clearing),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    assign red_out   = result.red;
    assign green_out = result.green;
    assign blue_out  = result.blue;
    assign alpha_out = result.alpha;
    assign in_range  = result.in_range;

endmodule
